// ===== hdl/mama_pkg.sv =====
package mama_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_WINDOW_DEF  = 64;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Configuration port layout.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTERED    = 1'b1;

  localparam logic [CFG_DATA_W-1:0] WINDOW_SIZE_RESET = 7'd4;
  localparam logic                  CENTERED_RESET    = 1'b1;

  // Bits of the output tuser field.
  localparam int unsigned OUT_USER_W = 2;

endpackage

// ===== hdl/missing_aware_moving_average.sv =====
// Moving average over the last window_size rows of a series, skipping missing samples.
//
// Input stream s_axis_*: one row per transfer, the sample in tdata, its missing flag in
// tuser and the end-of-series mark in tlast. Output stream m_axis_*: one result per
// transfer, the truncated average in tdata, {series_done, average_missing} in tuser and
// tlast on the final result caused by one input row.
// The cfg_* channel writes window_size (index 0) and centered (index 1); it is always
// ready and is meant to be used between rows only.
//
// Rows are handled one at a time. A row passes through an accept step, an update of the
// running sum from the ring memory (a read of the row leaving the window), a step that
// prepares the divide and the bit-serial divider, then an emit step for each result.
// The first row after a window_size write rebuilds the sum from the ring instead, one read
// per cycle, reading min(window, rows so far including this row) slots.
// In centered mode the first window_size/2 rows of a series give no result and the end
// of a series flushes the owed rows with the last average.
// Reset returns both registers to their reset values and empties the series; the ring
// contents need no clearing. While the receiver stalls the result holds in the output
// register and no new row is taken.
module missing_aware_moving_average #(
  parameter int unsigned MAX_WINDOW  = mama_pkg::MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = mama_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mama_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mama_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Input rows.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata,  // sample, zero padded
  input  logic                              s_axis_tlast,  // end_of_series
  input  logic [0:0]                        s_axis_tuser,  // sample_missing
  // Results.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]  m_axis_tdata,  // average, zero padded
  output logic                              m_axis_tlast,  // last_of_run
  output logic [mama_pkg::OUT_USER_W-1:0]   m_axis_tuser   // average_missing, series_done
);

  localparam int unsigned DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned LW     = CNT_W + 1;
  localparam int unsigned SUM_W  = SAMPLE_BITS + PTR_W;
  localparam int unsigned ITER_W = $clog2(SUM_W + 1);
  localparam int unsigned MEM_W  = SAMPLE_BITS + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UPD    = 3'd1;
  localparam logic [2:0] S_RECOMP = 3'd2;
  localparam logic [2:0] S_PREP   = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_WINDOW);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(MAX_WINDOW - 1);

  // Ring of recent rows: {present, value}.
  logic [MEM_W-1:0] ring_mem [MAX_WINDOW];
  logic [MEM_W-1:0] rd_data_q;
  logic             mem_we;
  logic             mem_re;
  logic [PTR_W-1:0] rd_addr;

  logic [2:0]                   state_q, state_d;
  logic [mama_pkg::CFG_DATA_W-1:0] win_q, win_d;
  logic                         centered_q, centered_d;
  logic                         stale_q, stale_d;
  logic signed [SUM_W-1:0]      sum_q, sum_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [PTR_W-1:0]             wp_q, wp_d;
  logic [CNT_W-1:0]             rows_q, rows_d;
  logic [SAMPLE_BITS-1:0]       new_val_q, new_val_d;
  logic                         new_pres_q, new_pres_d;
  logic                         eos_q, eos_d;
  logic                         has_leave_q, has_leave_d;
  logic [LW-1:0]                left_q, left_d;
  logic [PTR_W-1:0]             rp_q, rp_d;
  logic [CNT_W-1:0]             remain_q, remain_d;
  logic                         rdv_q, rdv_d;
  logic [SUM_W-1:0]             dvd_q, dvd_d;
  logic [CNT_W-1:0]             rem_q, rem_d;
  logic [CNT_W-1:0]             den_q, den_d;
  logic [ITER_W-1:0]            iter_q, iter_d;
  logic                         neg_q, neg_d;
  logic [SAMPLE_BITS-1:0]       avg_q, avg_d;
  logic                         miss_q, miss_d;

  logic                         in_fire;
  logic                         out_fire;
  logic                         cfg_fire;
  logic [CNT_W-1:0]             eff_win;
  logic [CNT_W-1:0]             delay;
  logic [CNT_W-1:0]             rows_new;
  logic [CNT_W-1:0]             n_recomp;
  logic [LW-1:0]                nres;
  logic [LW-1:0]                before_p1;
  logic [LW-1:0]                delay_p1;
  logic [LW-1:0]                leave_sum;
  logic [PTR_W-1:0]             leave_addr;
  logic [LW-1:0]                trial;
  logic signed [SUM_W-1:0]      new_ext;
  logic signed [SUM_W-1:0]      rd_ext;
  logic                         rd_pres;
  logic [SUM_W-1:0]             quot_sel;

  assign cfg_ready_o   = 1'b1;
  assign cfg_fire      = cfg_valid_i && cfg_ready_o;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state_q == S_EMIT);
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  assign m_axis_tdata  = DATA_W'(avg_q);
  assign m_axis_tlast  = (left_q == LW'(1));
  assign m_axis_tuser  = {m_axis_tlast && eos_q, miss_q};

  // Window length in force: zero acts as one, oversize values clamp.
  always_comb begin
    if (win_q == '0) begin
      eff_win = CNT_W'(1);
    end else if (win_q > mama_pkg::CFG_DATA_W'(MAX_WINDOW)) begin
      eff_win = MAX_CNT;
    end else begin
      eff_win = win_q[CNT_W-1:0];
    end
  end

  assign delay     = centered_q ? (eff_win >> 1) : '0;
  assign rows_new  = (rows_q < MAX_CNT) ? rows_q + CNT_W'(1) : rows_q;
  assign n_recomp  = (eff_win < rows_new) ? eff_win : rows_new;
  assign before_p1 = LW'(rows_q) + LW'(1);
  assign delay_p1  = LW'(delay) + LW'(1);

  always_comb begin
    if (s_axis_tlast) begin
      nres = (before_p1 < delay_p1) ? before_p1 : delay_p1;
    end else begin
      nres = (rows_q >= delay) ? LW'(1) : '0;
    end
  end

  // Slot of the row that drops out of the window when this row enters.
  assign leave_sum  = LW'(wp_q) + LW'(MAX_WINDOW) - LW'(eff_win);
  assign leave_addr = (leave_sum >= LW'(MAX_WINDOW)) ?
                      PTR_W'(leave_sum - LW'(MAX_WINDOW)) : PTR_W'(leave_sum);

  assign rd_pres = rd_data_q[MEM_W-1];
  assign rd_ext  = SUM_W'(signed'(rd_data_q[SAMPLE_BITS-1:0]));
  assign new_ext = SUM_W'(signed'(new_val_q));
  assign trial   = {rem_q, dvd_q[SUM_W-1]};

  assign quot_sel = dvd_q;

  assign mem_we  = in_fire;
  assign mem_re  = (in_fire && !stale_q) || (state_q == S_RECOMP && remain_q != '0);
  assign rd_addr = (state_q == S_IDLE) ? leave_addr : rp_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[wp_q] <= {!s_axis_tuser[0], s_axis_tdata[SAMPLE_BITS-1:0]};
    end
    if (mem_re) begin
      rd_data_q <= ring_mem[rd_addr];
    end
  end

  always_comb begin
    state_d     = state_q;
    win_d       = win_q;
    centered_d  = centered_q;
    stale_d     = stale_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    wp_d        = wp_q;
    rows_d      = rows_q;
    new_val_d   = new_val_q;
    new_pres_d  = new_pres_q;
    eos_d       = eos_q;
    has_leave_d = has_leave_q;
    left_d      = left_q;
    rp_d        = rp_q;
    remain_d    = remain_q;
    rdv_d       = 1'b0;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    den_d       = den_q;
    iter_d      = iter_q;
    neg_d       = neg_q;
    avg_d       = avg_q;
    miss_d      = miss_q;

    if (cfg_fire) begin
      case (cfg_index_i)
        mama_pkg::REG_WINDOW_SIZE: begin
          win_d   = cfg_data_i;
          stale_d = 1'b1;
        end
        mama_pkg::REG_CENTERED: centered_d = cfg_data_i[0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          new_val_d   = s_axis_tdata[SAMPLE_BITS-1:0];
          new_pres_d  = !s_axis_tuser[0];
          eos_d       = s_axis_tlast;
          left_d      = nres;
          has_leave_d = (rows_q >= eff_win);
          rows_d      = rows_new;
          wp_d        = (wp_q == LAST_PTR) ? '0 : wp_q + PTR_W'(1);
          if (stale_q) begin
            // Rebuild the window from the ring, newest row first.
            sum_d    = '0;
            cnt_d    = '0;
            rp_d     = wp_q;
            remain_d = n_recomp;
            state_d  = S_RECOMP;
          end else begin
            state_d = S_UPD;
          end
        end
      end
      S_UPD: begin
        sum_d = sum_q + (new_pres_q ? new_ext : '0)
                - ((has_leave_q && rd_pres) ? rd_ext : '0);
        cnt_d = cnt_q + (new_pres_q ? CNT_W'(1) : '0)
                - ((has_leave_q && rd_pres) ? CNT_W'(1) : '0);
        state_d = S_PREP;
      end
      S_RECOMP: begin
        if (remain_q != '0) begin
          rdv_d    = 1'b1;
          rp_d     = (rp_q == '0) ? LAST_PTR : rp_q - PTR_W'(1);
          remain_d = remain_q - CNT_W'(1);
        end
        if (rdv_q && rd_pres) begin
          sum_d = sum_q + rd_ext;
          cnt_d = cnt_q + CNT_W'(1);
        end
        if (remain_q == '0 && !rdv_q) begin
          stale_d = 1'b0;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        neg_d  = sum_q[SUM_W-1];
        dvd_d  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
        rem_d  = '0;
        den_d  = cnt_q;
        iter_d = ITER_W'(SUM_W);
        if (cnt_q == '0) begin
          avg_d   = '0;
          miss_d  = 1'b1;
          state_d = (left_q != '0) ? S_EMIT : S_IDLE;
        end else begin
          miss_d  = 1'b0;
          state_d = S_DIV;
        end
        if (eos_q) begin
          // The divider holds its own copy, so the series can clear now.
          sum_d   = '0;
          cnt_d   = '0;
          wp_d    = '0;
          rows_d  = '0;
          stale_d = 1'b0;
        end
      end
      S_DIV: begin
        if (iter_q != '0) begin
          if (trial >= LW'(den_q)) begin
            rem_d = CNT_W'(trial - LW'(den_q));
            dvd_d = {dvd_q[SUM_W-2:0], 1'b1};
          end else begin
            rem_d = CNT_W'(trial);
            dvd_d = {dvd_q[SUM_W-2:0], 1'b0};
          end
          iter_d = iter_q - ITER_W'(1);
        end else begin
          avg_d   = neg_q ? SAMPLE_BITS'(-quot_sel[SAMPLE_BITS-1:0])
                          : quot_sel[SAMPLE_BITS-1:0];
          state_d = (left_q != '0) ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_fire) begin
          if (left_q == LW'(1)) begin
            state_d = S_IDLE;
          end
          left_d = left_q - LW'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      win_q      <= mama_pkg::WINDOW_SIZE_RESET;
      centered_q <= mama_pkg::CENTERED_RESET;
      stale_q    <= 1'b0;
      sum_q      <= '0;
      cnt_q      <= '0;
      wp_q       <= '0;
      rows_q     <= '0;
      left_q     <= '0;
      remain_q   <= '0;
      rdv_q      <= 1'b0;
      iter_q     <= '0;
    end else begin
      state_q    <= state_d;
      win_q      <= win_d;
      centered_q <= centered_d;
      stale_q    <= stale_d;
      sum_q      <= sum_d;
      cnt_q      <= cnt_d;
      wp_q       <= wp_d;
      rows_q     <= rows_d;
      left_q     <= left_d;
      remain_q   <= remain_d;
      rdv_q      <= rdv_d;
      iter_q     <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_val_q   <= new_val_d;
    new_pres_q  <= new_pres_d;
    eos_q       <= eos_d;
    has_leave_q <= has_leave_d;
    rp_q        <= rp_d;
    dvd_q       <= dvd_d;
    rem_q       <= rem_d;
    den_q       <= den_d;
    neg_q       <= neg_d;
    avg_q       <= avg_d;
    miss_q      <= miss_d;
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("block did not leave idle after taking a row");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= rows_q) && (rows_q <= MAX_CNT))
    else $error("present count exceeds rows seen");

endmodule
